>>> design/tmse_pkg.sv
// tmse_pkg: shared types and constants of the touch median / scale / event block
// used by tmse_scale, the top level and the port checker
// no dependencies
`default_nettype none

package tmse_pkg;

	// screen size registers and scaled positions
	localparam int SIZE_W = 13;
	localparam int POS_W = 12;
	localparam logic [SIZE_W-1:0] POS_MAX = 13'd4095;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HSIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VSIZE = 1'd1;

	localparam logic [SIZE_W-1:0] HSIZE_RST = 13'd320;
	localparam logic [SIZE_W-1:0] VSIZE_RST = 13'd240;

	// event codes
	localparam int KIND_W = 2;
	typedef enum logic [KIND_W-1:0] {
		KIND_DOWN = 2'd0,
		KIND_MOVE = 2'd1,
		KIND_UP = 2'd2
	} event_kind_t;

	// control carried by the input stage
	typedef struct packed {
		logic emit;
		event_kind_t kind;
	} tmse_ctl_t;

endpackage

`default_nettype wire

>>> design/tmse_median3.sv
// tmse_median3: median of three unsigned samples, pure combinational
// depends on nothing
`default_nettype none

module tmse_median3 #(
	parameter int W = 12
) (
	input wire logic [W-1:0] a,
	input wire logic [W-1:0] b,
	input wire logic [W-1:0] c,
	output logic [W-1:0] med
);

	logic [W-1:0] lo;
	logic [W-1:0] hi;
	logic [W-1:0] mid;

	always_comb begin
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		mid = (hi < c) ? hi : c;
		med = (lo > mid) ? lo : mid;
	end

endmodule

`default_nettype wire

>>> design/tmse_scale.sv
// tmse_scale: raw median to screen pixel, (med * size) >> RAW_BITS with saturation
// depends on tmse_pkg
`default_nettype none

module tmse_scale #(
	parameter int RAW_BITS = 12
) (
	input wire logic [RAW_BITS-1:0] med,
	input wire logic [tmse_pkg::SIZE_W-1:0] size,
	output logic [tmse_pkg::POS_W-1:0] pos
);

	localparam int PROD_W = RAW_BITS + tmse_pkg::SIZE_W;

	logic [PROD_W-1:0] prod;
	logic [tmse_pkg::SIZE_W-1:0] shifted;

	assign prod = PROD_W'(med) * PROD_W'(size);
	assign shifted = prod[PROD_W-1:RAW_BITS];

	// clamp to the largest pixel position
	assign pos = (shifted > tmse_pkg::POS_MAX) ? tmse_pkg::POS_W'(tmse_pkg::POS_MAX)
		: shifted[tmse_pkg::POS_W-1:0];

endmodule

`default_nettype wire

>>> design/touch_median_scale_events.sv
// touch_median_scale_events: top level, input stage, event decision, output register
// depends on tmse_pkg, tmse_median3, tmse_scale
//
// channel  dir  handshake          payload
// s_*      in   tvalid/tready      tuser: pen_down; tdata: x0 x1 x2 y0 y1 y2
// m_*      out  tvalid/tready      tuser: event_kind; tdata: touch_x touch_y
// cfg_*    in   cfg_we, no wait    cfg_index selects horizontal/vertical size
//
// one word accepted per cycle while the output is not stalled; an accepted word is
// registered in the input stage, and its event then in the output register
// the median network plus one multiplier per axis between the input stage and the
// output register sets the cycle time
// arst_n clears the touched flag, the valid bits and restores default screen sizes
// a stalled output holds its word; while the output register waits, the input stage
// takes words only while it is empty or holds a word without event, and stops when both are full
`default_nettype none

module touch_median_scale_events #(
	parameter int RAW_BITS = 12
) (
	input wire logic clk,
	input wire logic arst_n,
	// configuration write port
	input wire logic cfg_we,
	input wire logic [tmse_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [tmse_pkg::SIZE_W-1:0] cfg_wdata,
	// poll words
	input wire logic s_tvalid,
	output logic s_tready,
	// sample_x0, sample_x1, sample_x2, sample_y0, sample_y1, sample_y2, zero fill
	input wire logic [((6*RAW_BITS+7)/8)*8-1:0] s_tdata,
	// pen_down
	input wire logic s_tuser,
	// event words
	output logic m_tvalid,
	input wire logic m_tready,
	// touch_x, touch_y
	output logic [2*tmse_pkg::POS_W-1:0] m_tdata,
	// event_kind
	output logic [tmse_pkg::KIND_W-1:0] m_tuser
);

	localparam int NSMP = 3;

	// configuration registers
	logic [tmse_pkg::SIZE_W-1:0] hsize_q;
	logic [tmse_pkg::SIZE_W-1:0] vsize_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsize_q <= tmse_pkg::HSIZE_RST;
			vsize_q <= tmse_pkg::VSIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tmse_pkg::REG_HSIZE: hsize_q <= cfg_wdata;
				tmse_pkg::REG_VSIZE: vsize_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake flow
	logic vld_s1;
	tmse_pkg::tmse_ctl_t ctl_s1;
	logic out_vld_q;
	logic out_free;
	logic s1_move;
	logic s_acc;

	assign out_free = !out_vld_q || m_tready;
	// a word that makes no event leaves the input stage without the output register
	assign s1_move = !ctl_s1.emit || out_free;
	assign s_tready = !vld_s1 || s1_move;
	assign s_acc = s_tvalid && s_tready;

	// touched flag and event decision, taken at accept so words can follow back to back
	logic touch_active_q;
	tmse_pkg::tmse_ctl_t ctl_in;

	always_comb begin
		ctl_in.emit = s_tuser || touch_active_q;
		if (s_tuser) begin
			ctl_in.kind = touch_active_q ? tmse_pkg::KIND_MOVE : tmse_pkg::KIND_DOWN;
		end else begin
			ctl_in.kind = tmse_pkg::KIND_UP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touch_active_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (s_acc) begin
				touch_active_q <= s_tuser;
				vld_s1 <= 1'b1;
			end else if (s1_move) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// input stage payload
	logic [RAW_BITS-1:0] smp_x_s1 [NSMP];
	logic [RAW_BITS-1:0] smp_y_s1 [NSMP];

	always_ff @(posedge clk) begin
		if (s_acc) begin
			ctl_s1 <= ctl_in;
		end
	end

	for (genvar i = 0; i < NSMP; i++) begin : g_smp
		always_ff @(posedge clk) begin
			if (s_acc) begin
				smp_x_s1[i] <= s_tdata[RAW_BITS*i +: RAW_BITS];
				smp_y_s1[i] <= s_tdata[RAW_BITS*(NSMP+i) +: RAW_BITS];
			end
		end
	end

	// median and scaling for both axes
	logic [RAW_BITS-1:0] med_x;
	logic [RAW_BITS-1:0] med_y;
	logic [tmse_pkg::POS_W-1:0] pos_x;
	logic [tmse_pkg::POS_W-1:0] pos_y;

	tmse_median3 #(.W(RAW_BITS)) u_med_x (
		.a(smp_x_s1[0]),
		.b(smp_x_s1[1]),
		.c(smp_x_s1[2]),
		.med(med_x)
	);

	tmse_median3 #(.W(RAW_BITS)) u_med_y (
		.a(smp_y_s1[0]),
		.b(smp_y_s1[1]),
		.c(smp_y_s1[2]),
		.med(med_y)
	);

	tmse_scale #(.RAW_BITS(RAW_BITS)) u_scale_x (
		.med(med_x),
		.size(hsize_q),
		.pos(pos_x)
	);

	tmse_scale #(.RAW_BITS(RAW_BITS)) u_scale_y (
		.med(med_y),
		.size(vsize_q),
		.pos(pos_y)
	);

	// output register
	logic out_load;
	logic is_up;
	tmse_pkg::event_kind_t kind_q;
	logic [tmse_pkg::POS_W-1:0] x_q;
	logic [tmse_pkg::POS_W-1:0] y_q;

	assign out_load = vld_s1 && ctl_s1.emit && out_free;
	assign is_up = (ctl_s1.kind == tmse_pkg::KIND_UP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q <= ctl_s1.kind;
			// up events report no position
			x_q <= is_up ? '0 : pos_x;
			y_q <= is_up ? '0 : pos_y;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser = kind_q;
	assign m_tdata = {y_q, x_q};

endmodule

`default_nettype wire

>>> design/tmse_checker.sv
// tmse_checker: port-level checks of touch_median_scale_events, bound to the top level
// depends on tmse_pkg
`default_nettype none

module tmse_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tready,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [2*tmse_pkg::POS_W-1:0] m_tdata,
	input wire logic [tmse_pkg::KIND_W-1:0] m_tuser
);

	// touched as seen from delivered events
	logic seen_touch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_touch_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			seen_touch_q <= (m_tuser != tmse_pkg::KIND_UP);
		end
	end

	// stalled event stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("event word dropped under stall");

	// up events carry no position
	a_up_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == tmse_pkg::KIND_UP) |-> (m_tdata == '0))
		else $error("up event with nonzero position");

	// down only from untouched, move and up only after a touch
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == tmse_pkg::KIND_DOWN) == !seen_touch_q))
		else $error("event kind out of sequence");

	// input backs up only behind a waiting event
	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled with output free");

endmodule

bind touch_median_scale_events tmse_checker u_tmse_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata),
	.m_tuser(m_tuser)
);

`default_nettype wire
